[rtl/line_centroid_pid_unit_assert.svh]
// Assertion macros used by the top-level RTL of the line centroid PID unit.
`ifndef LINE_CENTROID_PID_UNIT_ASSERT_SVH
`define LINE_CENTROID_PID_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define LCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define LCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lcp_pkg.sv]
`timescale 1ns / 1ps

package lcp_pkg;

    // Frame geometry and arithmetic widths.
    localparam int SENSOR_COUNT  = 9;
    localparam int SAMPLE_BITS   = 12;
    localparam int SUM_BITS      = 24;

    localparam int FIELD_COUNT   = 9;
    localparam int SAMPLE_W      = 12;
    localparam int THRESH_BITS   = 12;
    localparam int GAIN_BITS     = 14;
    localparam int LINE_GOAL     = 5000;
    localparam int POSITION_STEP = 1000;
    localparam int THRESH_RESET  = 2048;

    localparam int ADJUST_BITS   = 41;
    localparam int ERR_OUT_BITS  = 13;
    localparam int SEEN_OUT_BITS = 4;

    localparam int FRAME_BITS     = FIELD_COUNT * SAMPLE_W;
    localparam int IN_TDATA_BITS  = ((FRAME_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = ADJUST_BITS + ERR_OUT_BITS + SEEN_OUT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // Sample mask keeps only the compared sample bits.
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    // Centroid divider sizes.
    localparam int WSUM_MAX  = POSITION_STEP * SENSOR_COUNT * (SENSOR_COUNT + 1) / 2;
    localparam int WSUM_BITS = $clog2(WSUM_MAX + 1);
    localparam int SEEN_BITS = $clog2(SENSOR_COUNT + 1);
    localparam int REM_BITS  = SEEN_BITS;

    // Sequencer counter covers the scan, the divide and the multiply steps.
    localparam int CNT_BITS  = $clog2((SENSOR_COUNT > WSUM_BITS) ? SENSOR_COUNT : WSUM_BITS);
    localparam int MUL_STEPS = 3;

    // PID datapath widths.
    localparam int ERR_BITS  = WSUM_BITS + 1;
    localparam int DIFF_BITS = ERR_BITS + 1;
    localparam int MOP_BITS  = (SUM_BITS > DIFF_BITS) ? SUM_BITS : DIFF_BITS;
    localparam int PROD_BITS = GAIN_BITS + 1 + MOP_BITS;
    localparam int ACC_BITS  = (PROD_BITS + 2 > ADJUST_BITS + 1) ? PROD_BITS + 2
                                                                 : ADJUST_BITS + 1;
    localparam int SUMX_BITS = ((SUM_BITS > ERR_BITS) ? SUM_BITS : ERR_BITS) + 1;

    // Saturation limits.
    localparam longint SUM_HI = (longint'(1) <<< (SUM_BITS - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam longint ERR_HI = (longint'(1) <<< (ERR_OUT_BITS - 1)) - 1;
    localparam longint ERR_LO = -ERR_HI - 1;
    localparam longint ADJ_HI = (longint'(1) <<< (ADJUST_BITS - 1)) - 1;
    localparam longint ADJ_LO = -ADJ_HI - 1;

    // Register map indexes.
    typedef enum logic [1:0] {
        REG_THRESH = 2'd0,
        REG_GAIN_P = 2'd1,
        REG_GAIN_I = 2'd2,
        REG_GAIN_D = 2'd3
    } t_reg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_ERR,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } t_state;

    // Datapath operations issued by the sequencer.
    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LOAD,
        DP_SCAN,
        DP_DIV,
        DP_ERR,
        DP_SUM,
        DP_MUL
    } t_dp_op;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [1:0] {
        MS_P,
        MS_D,
        MS_I
    } t_mul_sel;

    typedef struct packed {
        t_dp_op   op;
        t_mul_sel mul_sel;
        logic     acc_en;
        logic     scan_live;
    } t_dp_ctrl;

    typedef struct packed {
        logic none_seen;
    } t_dp_stat;

    typedef struct packed {
        logic [THRESH_BITS-1:0] threshold;
        logic [GAIN_BITS-1:0]   gain_p;
        logic [GAIN_BITS-1:0]   gain_i;
        logic [GAIN_BITS-1:0]   gain_d;
    } t_cfg;

    // Saturate the widened integral back to its storage width.
    function automatic logic signed [SUM_BITS-1:0] sat_sum(
        input logic signed [SUMX_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] r;
        if (v > SUMX_BITS'(SUM_HI)) begin
            r = SUM_BITS'(SUM_HI);
        end else if (v < SUMX_BITS'(SUM_LO)) begin
            r = SUM_BITS'(SUM_LO);
        end else begin
            r = v[SUM_BITS-1:0];
        end
        return r;
    endfunction

    // Saturate an error to the stored previous-error width.
    function automatic logic signed [ERR_OUT_BITS-1:0] sat_err(
        input logic signed [ERR_BITS-1:0] v
    );
        logic signed [ERR_OUT_BITS-1:0] r;
        if (v > ERR_BITS'(ERR_HI)) begin
            r = ERR_OUT_BITS'(ERR_HI);
        end else if (v < ERR_BITS'(ERR_LO)) begin
            r = ERR_OUT_BITS'(ERR_LO);
        end else begin
            r = v[ERR_OUT_BITS-1:0];
        end
        return r;
    endfunction

    // Saturate the accumulated correction to the output width.
    function automatic logic signed [ADJUST_BITS-1:0] sat_adj(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [ADJUST_BITS-1:0] r;
        if (v > ACC_BITS'(ADJ_HI)) begin
            r = ADJUST_BITS'(ADJ_HI);
        end else if (v < ACC_BITS'(ADJ_LO)) begin
            r = ADJUST_BITS'(ADJ_LO);
        end else begin
            r = v[ADJUST_BITS-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/lcp_apb_regs.sv]
`timescale 1ns / 1ps

module lcp_apb_regs import lcp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    logic [THRESH_BITS-1:0] r_thresh;
    logic [GAIN_BITS-1:0]   r_gain_p;
    logic [GAIN_BITS-1:0]   r_gain_i;
    logic [GAIN_BITS-1:0]   r_gain_d;
    t_reg_idx               w_idx;
    logic                   w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes complete in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_BITS'(THRESH_RESET);
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_THRESH: r_thresh <= pwdata[THRESH_BITS-1:0];
                REG_GAIN_P: r_gain_p <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_I: r_gain_i <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_D: r_gain_d <= pwdata[GAIN_BITS-1:0];
            endcase
        end
    end

    // Read back of the addressed register.
    always_comb begin
        unique case (w_idx)
            REG_THRESH: prdata = APB_DATA_BITS'(r_thresh);
            REG_GAIN_P: prdata = APB_DATA_BITS'(r_gain_p);
            REG_GAIN_I: prdata = APB_DATA_BITS'(r_gain_i);
            REG_GAIN_D: prdata = APB_DATA_BITS'(r_gain_d);
        endcase
    end

    assign o_cfg.threshold = r_thresh;
    assign o_cfg.gain_p    = r_gain_p;
    assign o_cfg.gain_i    = r_gain_i;
    assign o_cfg.gain_d    = r_gain_d;

endmodule

[rtl/lcp_datapath.sv]
`timescale 1ns / 1ps

module lcp_datapath import lcp_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_ctrl                       i_ctrl,
    input  t_cfg                           i_cfg,
    input  logic [FRAME_BITS-1:0]          i_frame,
    output t_dp_stat                       o_stat,
    output logic signed [ADJUST_BITS-1:0]  o_adjust,
    output logic signed [ERR_OUT_BITS-1:0] o_error,
    output logic [SEEN_OUT_BITS-1:0]       o_seen,
    output logic                           o_no_line
);

    logic [SAMPLE_W-1:0]         r_smp [FIELD_COUNT];
    logic [SEEN_BITS-1:0]        r_seen;
    logic [WSUM_BITS-1:0]        r_pos;
    logic [WSUM_BITS-1:0]        r_quo;
    logic [REM_BITS-1:0]         r_rem;
    logic signed [ERR_BITS-1:0]  r_err;
    logic signed [DIFF_BITS-1:0] r_diff;
    logic signed [SUM_BITS-1:0]  r_sum;
    logic signed [ERR_OUT_BITS-1:0] r_last;
    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;

    logic                        w_hit;
    logic [REM_BITS:0]           w_shift;
    logic [REM_BITS:0]           w_div;
    logic                        w_ge;
    logic signed [SUMX_BITS-1:0] w_sumx;
    logic signed [GAIN_BITS:0]   w_gain;
    logic signed [MOP_BITS-1:0]  w_mop;
    logic signed [PROD_BITS-1:0] w_prod;

    // Threshold compare on the sample at the head of the shift line.
    assign w_hit = i_ctrl.scan_live && ((r_smp[0] & SAMPLE_MASK) >= i_cfg.threshold);

    // One restoring division step: remainder shifts in the next dividend bit.
    assign w_shift = {r_rem, r_quo[WSUM_BITS-1]};
    assign w_div   = {1'b0, r_seen};
    assign w_ge    = (w_shift >= w_div);

    // Widened integral update before saturation.
    assign w_sumx = SUMX_BITS'(r_sum) + SUMX_BITS'(r_err);

    // Shared multiplier operand selection.
    always_comb begin
        unique case (i_ctrl.mul_sel)
            MS_P: begin
                w_gain = $signed({1'b0, i_cfg.gain_p});
                w_mop  = MOP_BITS'(r_err);
            end
            MS_D: begin
                w_gain = $signed({1'b0, i_cfg.gain_d});
                w_mop  = MOP_BITS'(r_diff);
            end
            MS_I: begin
                w_gain = $signed({1'b0, i_cfg.gain_i});
                w_mop  = MOP_BITS'(r_sum);
            end
            default: begin
                w_gain = '0;
                w_mop  = '0;
            end
        endcase
    end

    assign w_prod = w_gain * w_mop;

    // Frame scan, centroid divide, error formation, error difference and product capture.
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            DP_LOAD: begin
                for (int k = 0; k < FIELD_COUNT; k++) begin
                    r_smp[k] <= i_frame[k*SAMPLE_W +: SAMPLE_W];
                end
                r_seen <= '0;
                r_pos  <= WSUM_BITS'(POSITION_STEP);
                r_quo  <= '0;
                r_rem  <= '0;
            end
            DP_SCAN: begin
                for (int k = 0; k < FIELD_COUNT - 1; k++) begin
                    r_smp[k] <= r_smp[k+1];
                end
                r_smp[FIELD_COUNT-1] <= '0;
                r_pos <= r_pos + WSUM_BITS'(POSITION_STEP);
                if (w_hit) begin
                    r_quo  <= r_quo + r_pos;
                    r_seen <= r_seen + 1'b1;
                end
            end
            DP_DIV: begin
                r_quo <= {r_quo[WSUM_BITS-2:0], w_ge};
                r_rem <= w_ge ? REM_BITS'(w_shift - w_div) : REM_BITS'(w_shift);
            end
            DP_ERR: begin
                r_err <= $signed(ERR_BITS'(LINE_GOAL) - ERR_BITS'({1'b0, r_quo}));
            end
            DP_SUM: begin
                r_diff <= DIFF_BITS'(r_err) - DIFF_BITS'(r_last);
            end
            DP_MUL: begin
                r_prod <= w_prod;
            end
            DP_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    // Loop state: integral and previous error move only on frames with a line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_ctrl.op == DP_SUM) begin
            r_sum  <= sat_sum(w_sumx);
            r_last <= sat_err(r_err);
        end
    end

    // Accumulator for the three products.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == DP_SUM) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc + ACC_BITS'(r_prod);
        end
    end

    assign o_stat.none_seen = (r_seen == '0);
    assign o_no_line        = (r_seen == '0);
    assign o_seen           = SEEN_OUT_BITS'(r_seen);
    assign o_error          = o_no_line ? '0 : r_err[ERR_OUT_BITS-1:0];
    assign o_adjust         = o_no_line ? '0 : sat_adj(r_acc);

endmodule

[rtl/lcp_ctrl.sv]
`timescale 1ns / 1ps

module lcp_ctrl import lcp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl,
    output logic     o_ready,
    output logic     o_done
);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and step counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                    n_cnt   = '0;
                end
            end
            ST_SCAN: begin
                if (r_cnt == CNT_BITS'(SENSOR_COUNT - 1)) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DIV: begin
                if (i_stat.none_seen) begin
                    n_state = ST_OUT;
                end else if (r_cnt == CNT_BITS'(WSUM_BITS - 1)) begin
                    n_state = ST_ERR;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ERR: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_MUL;
                n_cnt   = '0;
            end
            ST_MUL: begin
                if (r_cnt == CNT_BITS'(MUL_STEPS)) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_OUT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath commands for the current state.
    always_comb begin
        o_ctrl.op        = DP_HOLD;
        o_ctrl.mul_sel   = MS_P;
        o_ctrl.acc_en    = 1'b0;
        o_ctrl.scan_live = 1'b0;
        o_ready          = 1'b0;
        o_done           = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready   = 1'b1;
                o_ctrl.op = i_start ? DP_LOAD : DP_HOLD;
            end
            ST_SCAN: begin
                o_ctrl.op        = DP_SCAN;
                o_ctrl.scan_live = (r_cnt < CNT_BITS'(FIELD_COUNT));
            end
            ST_DIV: begin
                o_ctrl.op = i_stat.none_seen ? DP_HOLD : DP_DIV;
            end
            ST_ERR: begin
                o_ctrl.op = DP_ERR;
            end
            ST_SUM: begin
                o_ctrl.op = DP_SUM;
            end
            ST_MUL: begin
                // Product k is formed at step k and added one step later.
                o_ctrl.op     = (r_cnt < CNT_BITS'(MUL_STEPS)) ? DP_MUL : DP_HOLD;
                o_ctrl.acc_en = (r_cnt != '0);
                priority if (r_cnt == CNT_BITS'(0)) begin
                    o_ctrl.mul_sel = MS_P;
                end else if (r_cnt == CNT_BITS'(1)) begin
                    o_ctrl.mul_sel = MS_D;
                end else begin
                    o_ctrl.mul_sel = MS_I;
                end
            end
            ST_OUT: begin
                o_done = i_out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/line_centroid_pid_unit.sv]
// Line centroid PID unit. Each input beat carries nine 12-bit sensor samples;
// the unit thresholds them, divides the summed positions of the seen sensors
// by their count, and returns one result beat with the PID correction, the
// position error, the seen count and a no-line flag. A frame occupies the
// unit from accept until its result is registered: the sensor scan, the
// restoring divider at one quotient bit per cycle, the error and integral
// update, then the single shared multiplier and accumulator. The next frame
// is accepted in the cycle after the result is registered; a frame with no
// line seen skips to the output. A result waits in the output register and
// holds back the next one until the sink takes it. The user must write gains
// and the threshold over APB while no frame is in flight; it is not checked.
`timescale 1ns / 1ps
`include "line_centroid_pid_unit_assert.svh"

module line_centroid_pid_unit import lcp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample_0 .. sample_8, 12 bits each from bit 0 up, zero padded
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // drive_adjust[40:0], position_error[53:41], seen_count[57:54], zero padded
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    // no_line[0]
    output logic [0:0]                m_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready
);

    t_cfg                           w_cfg;
    t_dp_ctrl                       w_ctrl;
    t_dp_stat                       w_stat;
    logic                           w_ready;
    logic                           w_done;
    logic                           w_start;
    logic                           w_out_free;
    logic signed [ADJUST_BITS-1:0]  w_adjust;
    logic signed [ERR_OUT_BITS-1:0] w_error;
    logic [SEEN_OUT_BITS-1:0]       w_seen;
    logic                           w_no_line;

    logic                           r_m_valid;
    logic signed [ADJUST_BITS-1:0]  r_m_adj;
    logic signed [ERR_OUT_BITS-1:0] r_m_err;
    logic [SEEN_OUT_BITS-1:0]       r_m_seen;
    logic                           r_m_nol;

    assign s_axis_tready = w_ready && i_rst_n;
    assign w_start       = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    lcp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl),
        .o_ready    (w_ready),
        .o_done     (w_done)
    );

    lcp_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_cfg     (w_cfg),
        .i_frame   (s_axis_tdata[FRAME_BITS-1:0]),
        .o_stat    (w_stat),
        .o_adjust  (w_adjust),
        .o_error   (w_error),
        .o_seen    (w_seen),
        .o_no_line (w_no_line)
    );

    // Output register: holds a finished beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_m_adj  <= w_adjust;
            r_m_err  <= w_error;
            r_m_seen <= w_seen;
            r_m_nol  <= w_no_line;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {OUT_PAD_BITS'(0), r_m_seen, r_m_err, r_m_adj};
    assign m_axis_tuser  = r_m_nol;

    // The unit is busy for the cycle after it takes a frame.
    `LCP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready, "frame accepted while busy")
    // A no-line result carries zero correction, error and count.
    `LCP_ASSERT_NOW(a_no_line_zero, i_clk, i_rst_n,
        r_m_valid && r_m_nol, (r_m_adj == '0) && (r_m_err == '0) && (r_m_seen == '0),
        "no-line result with nonzero fields")
    // A result with a line always counts at least one sensor.
    `LCP_ASSERT_NOW(a_line_has_count, i_clk, i_rst_n,
        r_m_valid && !r_m_nol, r_m_seen != '0, "line result with zero seen count")
    // A new result appears only at the end of a busy period.
    `LCP_ASSERT_NOW(a_result_after_work, i_clk, i_rst_n,
        $rose(r_m_valid), $past(!w_ready), "result produced while sequencer idle")

endmodule

[bench/line_centroid_pid_unit_tb.sv]
`timescale 1ns / 1ps

module line_centroid_pid_unit_tb;
    import lcp_pkg::*;

    // One sensor frame, sample 0 in the lowest bits.
    typedef logic [FIELD_COUNT-1:0][SAMPLE_W-1:0] t_frame;

    // One result beat split into its fields.
    typedef struct packed {
        logic signed [ADJUST_BITS-1:0]   adjust;
        logic signed [ERR_OUT_BITS-1:0]  pos_err;
        logic        [SEEN_OUT_BITS-1:0] seen;
        logic                            no_line;
    } t_pid_result;

    // Probe frame: sensors marked in lit read hi_level, the others lo_level.
    typedef struct packed {
        logic [FIELD_COUNT-1:0] lit;
        logic [SAMPLE_W-1:0]    hi_level;
        logic [SAMPLE_W-1:0]    lo_level;
        t_pid_result            res;
    } t_probe_row;

    localparam longint INTEG_MAX      = (longint'(1) <<< (SUM_BITS - 1)) - 1;
    localparam longint INTEG_MIN      = -INTEG_MAX - 1;
    localparam longint ADJUST_MAX     = (longint'(1) <<< (ADJUST_BITS - 1)) - 1;
    localparam longint ADJUST_MIN     = -ADJUST_MAX - 1;
    localparam int     SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
    localparam int     GAIN_MAX       = 9999;
    localparam int     PROBE_ROWS     = 13;
    localparam int     RAND_PHASES    = 8;
    localparam int     PHASE_FRAMES   = 150;
    localparam int     HOLD_PHASE     = 3;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     SWEEP_THRESH   = 2048;
    localparam int     SWEEP_UP       = 150;
    localparam int     SWEEP_DOWN     = 300;
    localparam int     TAIL_CYCLES    = 60;
    localparam int     WATCHDOG_LIMIT = 3000;

    localparam int THRESH_PICKS [4] = '{0, SAMPLE_MAX, 1, 2048};

    // Probe frames. Expectations hold for the reset register values, where
    // all gains are zero and the correction therefore stays zero.
    localparam t_probe_row PROBES [PROBE_ROWS] = '{
        '{9'b000000000, 12'h000, 12'h000, '{41'sd0, 13'sd0, 4'd0, 1'b1}},
        '{9'b111111111, 12'hFFF, 12'h000, '{41'sd0, 13'sd0, 4'd9, 1'b0}},
        '{9'b000000001, 12'hFFF, 12'h000, '{41'sd0, 13'sd4000, 4'd1, 1'b0}},
        '{9'b100000000, 12'hFFF, 12'h000, '{41'sd0, -13'sd4000, 4'd1, 1'b0}},
        '{9'b000000000, 12'h000, 12'h7FF, '{41'sd0, 13'sd0, 4'd0, 1'b1}},
        '{9'b111111111, 12'h800, 12'h000, '{41'sd0, 13'sd0, 4'd9, 1'b0}},
        '{9'b100000001, 12'h800, 12'h7FF, '{41'sd0, 13'sd0, 4'd2, 1'b0}},
        '{9'b000000011, 12'hFFF, 12'h000, '{41'sd0, 13'sd3500, 4'd2, 1'b0}},
        '{9'b000001011, 12'hFFF, 12'h7FF, '{41'sd0, 13'sd2667, 4'd3, 1'b0}},
        '{9'b110000000, 12'h800, 12'h000, '{41'sd0, -13'sd3500, 4'd2, 1'b0}},
        '{9'b101010101, 12'hAAA, 12'h555, '{41'sd0, 13'sd0, 4'd5, 1'b0}},
        '{9'b010101010, 12'hAAA, 12'h555, '{41'sd0, 13'sd0, 4'd4, 1'b0}},
        '{9'b011100000, 12'hC00, 12'h3FF, '{41'sd0, -13'sd2000, 4'd3, 1'b0}}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    // sample_0 .. sample_8, 12 bits each from bit 0 up
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // drive_adjust, position_error, seen_count from bit 0 up
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    // no_line
    logic [0:0]                m_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr = '0;
    logic [APB_DATA_BITS-1:0]  pwdata = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    // Register mirror and loop state of the predictor.
    longint cfg_threshold = THRESH_RESET;
    longint cfg_kp = 0;
    longint cfg_ki = 0;
    longint cfg_kd = 0;
    longint integ_sum = 0;
    longint prev_err = 0;

    t_pid_result pending_corrections [$];
    int          mismatch_count = 0;
    int unsigned src_idle_max = 5;
    int unsigned snk_idle_max = 5;
    bit          hold_out_req = 1'b0;
    int          idle_cycles = 0;

    line_centroid_pid_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Centroid of the lit sensors, then the PID update. A frame with no
    // lit sensor leaves the integral and the previous error untouched.
    function automatic t_pid_result predict_correction(input t_frame f);
        t_pid_result r;
        longint      weight;
        longint      count;
        longint      err;
        longint      adj;
        r = '0;
        weight = 0;
        count = 0;
        for (int k = 0; k < FIELD_COUNT; k++) begin
            if (f[k] >= cfg_threshold) begin
                weight += POSITION_STEP * (k + 1);
                count++;
            end
        end
        if (count == 0) begin
            r.no_line = 1'b1;
            return r;
        end
        err = LINE_GOAL - weight / count;
        integ_sum += err;
        if (integ_sum > INTEG_MAX) integ_sum = INTEG_MAX;
        if (integ_sum < INTEG_MIN) integ_sum = INTEG_MIN;
        adj = cfg_kp * err + cfg_kd * (err - prev_err) + cfg_ki * integ_sum;
        if (adj > ADJUST_MAX) adj = ADJUST_MAX;
        if (adj < ADJUST_MIN) adj = ADJUST_MIN;
        prev_err = err;
        r.adjust = adj[ADJUST_BITS-1:0];
        r.pos_err = err[ERR_OUT_BITS-1:0];
        r.seen = count[SEEN_OUT_BITS-1:0];
        return r;
    endfunction

    // Random frame: mostly a short lit stretch on a dark floor, some dark
    // frames and some plain noise.
    function automatic t_frame make_frame(input longint thr);
        t_frame      f;
        int unsigned kind;
        int unsigned first;
        int unsigned span;
        kind = $urandom_range(0, 99);
        for (int k = 0; k < FIELD_COUNT; k++) f[k] = SAMPLE_W'($urandom);
        if (kind < 25) return f;
        if (thr > 0) begin
            for (int k = 0; k < FIELD_COUNT; k++) begin
                f[k] = SAMPLE_W'($urandom_range(0, thr - 1));
            end
        end
        if (kind < 40) return f;
        first = $urandom_range(0, FIELD_COUNT - 1);
        span = $urandom_range(1, 3);
        for (int k = first; k < first + span && k < FIELD_COUNT; k++) begin
            f[k] = SAMPLE_W'($urandom_range(thr, SAMPLE_MAX));
        end
        return f;
    endfunction

    function automatic longint pick_gain();
        int unsigned sel;
        sel = $urandom_range(0, 3);
        if (sel == 0) return 0;
        if (sel == 1) return GAIN_MAX;
        return $urandom_range(0, GAIN_MAX);
    endfunction

    task automatic shuffle_idling();
        src_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
        snk_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
    endtask

    // APB read of one register, compared with the value it should hold.
    task automatic reg_check(input t_reg_idx idx, input longint value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= APB_ADDR_BITS'(4 * idx);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DATA_BITS'(value)) begin
            $error("register %s: expected %0d, actual %0d", idx.name(), value, prdata);
            mismatch_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // APB write, mirrored into the predictor, then read back.
    task automatic set_register(input t_reg_idx idx, input longint value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_BITS'(4 * idx);
        pwdata <= APB_DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_THRESH: cfg_threshold = value;
            REG_GAIN_P: cfg_kp = value;
            REG_GAIN_I: cfg_ki = value;
            REG_GAIN_D: cfg_kd = value;
            default: ;
        endcase
        reg_check(idx, value);
    endtask

    // Offer one frame after a random gap; predict its result on accept.
    task automatic send_frame(input t_frame f, input bit typed, input t_pid_result typed_res);
        int unsigned gap;
        t_pid_result calc;
        gap = $urandom_range(0, src_idle_max);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= IN_TDATA_BITS'(f);
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        calc = predict_correction(f);
        pending_corrections.push_back(typed ? typed_res : calc);
    endtask

    // Stop offering and let every outstanding result come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_corrections.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Result side: random stalls, one long hold on request, field checks.
    initial begin : result_sink
        t_pid_result got;
        t_pid_result want;
        int unsigned stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, snk_idle_max);
            if (hold_out_req) begin
                hold_out_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got.adjust = m_axis_tdata[ADJUST_BITS-1:0];
            got.pos_err = m_axis_tdata[ADJUST_BITS +: ERR_OUT_BITS];
            got.seen = m_axis_tdata[ADJUST_BITS + ERR_OUT_BITS +: SEEN_OUT_BITS];
            got.no_line = m_axis_tuser[0];
            if (pending_corrections.size() == 0) begin
                $error("result beat with no frame outstanding");
                mismatch_count++;
            end else begin
                want = pending_corrections.pop_front();
                if (got.adjust !== want.adjust) begin
                    $error("drive_adjust: expected %0d, actual %0d", want.adjust, got.adjust);
                    mismatch_count++;
                end
                if (got.pos_err !== want.pos_err) begin
                    $error("position_error: expected %0d, actual %0d",
                           want.pos_err, got.pos_err);
                    mismatch_count++;
                end
                if (got.seen !== want.seen) begin
                    $error("seen_count: expected %0d, actual %0d", want.seen, got.seen);
                    mismatch_count++;
                end
                if (got.no_line !== want.no_line) begin
                    $error("no_line: expected %0d, actual %0d", want.no_line, got.no_line);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat or register access.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : frame_source
        t_frame frame;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register values right after reset.
        reg_check(REG_THRESH, THRESH_RESET);
        reg_check(REG_GAIN_P, 0);
        reg_check(REG_GAIN_I, 0);
        reg_check(REG_GAIN_D, 0);

        // Probe frames: first under reset values with fixed expectations,
        // then again with threshold 1 and all gains at GAIN_MAX.
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) begin
                wait_drained();
                set_register(REG_THRESH, 1);
                set_register(REG_GAIN_P, GAIN_MAX);
                set_register(REG_GAIN_I, GAIN_MAX);
                set_register(REG_GAIN_D, GAIN_MAX);
            end
            for (int r = 0; r < PROBE_ROWS; r++) begin
                for (int k = 0; k < FIELD_COUNT; k++) begin
                    frame[k] = PROBES[r].lit[k] ? PROBES[r].hi_level : PROBES[r].lo_level;
                end
                send_frame(frame, pass == 0, PROBES[r].res);
            end
        end

        // Random frames over several register settings. One phase runs the
        // sender flat out against a long hold on the result side.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            set_register(REG_THRESH, (ph < 4) ? THRESH_PICKS[ph] : $urandom_range(0, SAMPLE_MAX));
            set_register(REG_GAIN_P, pick_gain());
            set_register(REG_GAIN_I, pick_gain());
            set_register(REG_GAIN_D, pick_gain());
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                if (n % 40 == 0) shuffle_idling();
                if (ph == HOLD_PHASE && n == 0) begin
                    src_idle_max = 0;
                    hold_out_req = 1'b1;
                end
                send_frame(make_frame(cfg_threshold), 1'b0, '0);
            end
        end

        // Push the integral far positive with the line at the left edge,
        // then far negative with the line at the right edge.
        wait_drained();
        set_register(REG_THRESH, SWEEP_THRESH);
        set_register(REG_GAIN_P, pick_gain());
        set_register(REG_GAIN_I, GAIN_MAX);
        set_register(REG_GAIN_D, pick_gain());
        for (int n = 0; n < SWEEP_UP + SWEEP_DOWN; n++) begin
            if (n % 40 == 0) shuffle_idling();
            for (int k = 0; k < FIELD_COUNT; k++) begin
                frame[k] = SAMPLE_W'($urandom_range(0, SWEEP_THRESH - 1));
            end
            frame[(n < SWEEP_UP) ? 0 : FIELD_COUNT - 1] =
                SAMPLE_W'($urandom_range(SWEEP_THRESH, SAMPLE_MAX));
            send_frame(frame, 1'b0, '0);
        end
        for (int n = 0; n < 40; n++) begin
            send_frame(make_frame(cfg_threshold), 1'b0, '0);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
